@@ src/fpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types and constants of the framed packet parser.
// ----------------------------------------------------------------------------
package fpp_pkg;

    localparam int DEF_PLAIN_HEADER_BYTES  = 8;
    localparam int DEF_SECURE_HEADER_BYTES = 20;
    localparam int DEF_TRAILER_BYTES       = 2;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 12;
    localparam int PHASE_W = 3;

    // register indexes on the configuration port
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_BYTE   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENCRYPT_MASK = 1'd1;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET   = 8'hA5;
    localparam logic [BYTE_W-1:0] ENCRYPT_MASK_RESET = 8'h01;

    typedef struct packed {
        logic               frame_done;
        logic               payload_valid;
        logic [COUNT_W-1:0] payload_index;
        logic [BYTE_W-1:0]  payload_byte;
        logic [COUNT_W-1:0] message_id;
        logic [COUNT_W-1:0] payload_length;
        logic               is_encrypted;
    } fpp_result_t;

endpackage

@@ src/fpp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_core
// Frame state and the per-byte update; gives the result of the byte that is
// being taken.
// ----------------------------------------------------------------------------
module fpp_core
    import fpp_pkg::*;
#(
    parameter int PLAIN_HEADER_BYTES  = DEF_PLAIN_HEADER_BYTES,
    parameter int SECURE_HEADER_BYTES = DEF_SECURE_HEADER_BYTES,
    parameter int TRAILER_BYTES       = DEF_TRAILER_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] start_byte,
    input  logic [BYTE_W-1:0] encrypt_mask,
    output fpp_result_t       result
);

    localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_BASE    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXT     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TRAILER = 3'd4;

    localparam int POS_W = COUNT_W + 1;
    localparam logic [POS_W-1:0] BASE_END   = POS_W'(4);
    localparam logic [POS_W-1:0] PLAIN_END  = POS_W'(PLAIN_HEADER_BYTES);
    localparam logic [POS_W-1:0] SECURE_END = POS_W'(SECURE_HEADER_BYTES);
    localparam logic [POS_W-1:0] TRAIL_END  = POS_W'(TRAILER_BYTES);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]  len_hi_reg, len_hi_next;
    logic [BYTE_W-1:0]  len_mid_reg, len_mid_next;
    logic [BYTE_W-1:0]  flags_reg, flags_next;
    logic [BYTE_W-1:0]  id_hi_reg, id_hi_next;
    logic [COUNT_W-1:0] length_reg, length_next;
    logic [COUNT_W-1:0] msg_id_reg, msg_id_next;

    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   header_end;
    logic               done;
    logic               pvalid;

    assign pos_inc    = {1'b0, count_reg} + POS_W'(1);
    assign header_end = ((flags_reg & encrypt_mask) != '0) ? SECURE_END : PLAIN_END;

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        len_hi_next  = len_hi_reg;
        len_mid_next = len_mid_reg;
        flags_next   = flags_reg;
        id_hi_next   = id_hi_reg;
        length_next  = length_reg;
        msg_id_next  = msg_id_reg;
        done         = 1'b0;
        pvalid       = 1'b0;
        case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == start_byte) begin
                    phase_next = PH_BASE;
                    count_next = COUNT_W'(1);
                end
            end
            PH_BASE: begin
                if (count_reg == COUNT_W'(1)) len_hi_next  = rx_byte;
                if (count_reg == COUNT_W'(2)) len_mid_next = rx_byte;
                if (count_reg == COUNT_W'(3)) flags_next   = rx_byte;
                count_next = pos_inc[COUNT_W-1:0];
                if (pos_inc >= BASE_END) begin
                    length_next = {len_hi_next[7:4], len_mid_next[5:0], flags_next[7:6]};
                    phase_next  = PH_EXT;
                end
            end
            PH_EXT: begin
                if (count_reg == COUNT_W'(6)) id_hi_next = rx_byte;
                if (count_reg == COUNT_W'(7)) msg_id_next = {id_hi_reg[3:0], rx_byte};
                count_next = pos_inc[COUNT_W-1:0];
                if (pos_inc >= header_end) begin
                    count_next = '0;
                    phase_next = (length_reg == '0) ? PH_TRAILER : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                pvalid     = 1'b1;
                count_next = pos_inc[COUNT_W-1:0];
                if (pos_inc >= {1'b0, length_reg}) begin
                    phase_next = PH_TRAILER;
                    count_next = '0;
                end
            end
            PH_TRAILER: begin
                count_next = pos_inc[COUNT_W-1:0];
                if (pos_inc >= TRAIL_END) begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                    done       = 1'b1;
                end
            end
            default: begin
                phase_next = PH_HUNT;
                count_next = '0;
            end
        endcase
    end

    always_comb begin
        result.frame_done     = done;
        result.payload_valid  = pvalid;
        result.payload_index  = pvalid ? count_reg : '0;
        result.payload_byte   = pvalid ? rx_byte : '0;
        result.message_id     = msg_id_next;
        result.payload_length = length_next;
        result.is_encrypted   = (flags_next & encrypt_mask) != '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            count_reg   <= '0;
            len_hi_reg  <= '0;
            len_mid_reg <= '0;
            flags_reg   <= '0;
            id_hi_reg   <= '0;
            length_reg  <= '0;
            msg_id_reg  <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            len_hi_reg  <= len_hi_next;
            len_mid_reg <= len_mid_next;
            flags_reg   <= flags_next;
            id_hi_reg   <= id_hi_next;
            length_reg  <= length_next;
            msg_id_reg  <= msg_id_next;
        end
    end

endmodule

@@ src/framed_packet_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_parser_top
// Byte-wide framed packet parser with a registered result channel.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received byte per item (valid/ready). Every byte gives
//   exactly one result item on m_*: payload bytes come out with their index,
//   the last trailer byte raises m_frame_done, and every item shows the
//   current message id, payload length and encrypted flag.
//   The result is registered: a byte taken at one edge has its result on m_*
//   after that edge. Throughput is one byte per cycle while m_ready is high,
//   set by the single state update in fpp_core feeding the result register.
//   When the receiver stalls, the result register holds and s_ready drops
//   until the held item is taken; s_ready is high again in the cycle the
//   result is taken, so there is no bubble.
//   Reset (aresetn low, synchronous) returns to the hunt for the start byte,
//   clears the frame state, empties the result register and loads the
//   registers with start byte 0xA5 and encrypt mask 0x01.
//   Write cfg_* only while the block is idle.
// ----------------------------------------------------------------------------
module framed_packet_parser_top
    import fpp_pkg::*;
#(
    parameter int PLAIN_HEADER_BYTES  = DEF_PLAIN_HEADER_BYTES,
    parameter int SECURE_HEADER_BYTES = DEF_SECURE_HEADER_BYTES,
    parameter int TRAILER_BYTES       = DEF_TRAILER_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [BYTE_W-1:0]     cfg_wr_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_rx_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_frame_done,
    output logic                  m_payload_valid,
    output logic [COUNT_W-1:0]    m_payload_index,
    output logic [BYTE_W-1:0]     m_payload_byte,
    output logic [COUNT_W-1:0]    m_message_id,
    output logic [COUNT_W-1:0]    m_payload_length,
    output logic                  m_is_encrypted
);

    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] mask_reg;
    logic              out_valid_reg;
    fpp_result_t       out_reg;
    fpp_result_t       step_result;
    logic              accept;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    fpp_core #(
        .PLAIN_HEADER_BYTES  (PLAIN_HEADER_BYTES),
        .SECURE_HEADER_BYTES (SECURE_HEADER_BYTES),
        .TRAILER_BYTES       (TRAILER_BYTES)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (accept),
        .rx_byte      (s_rx_byte),
        .start_byte   (start_byte_reg),
        .encrypt_mask (mask_reg),
        .result       (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= START_BYTE_RESET;
            mask_reg       <= ENCRYPT_MASK_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_START_BYTE:   start_byte_reg <= cfg_wr_data;
                CFG_ENCRYPT_MASK: mask_reg       <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= step_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_done     = out_reg.frame_done;
    assign m_payload_valid  = out_reg.payload_valid;
    assign m_payload_index  = out_reg.payload_index;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_message_id     = out_reg.message_id;
    assign m_payload_length = out_reg.payload_length;
    assign m_is_encrypted   = out_reg.is_encrypted;

endmodule
